FILE: rtl/mwfb_pkg.sv
// constants, byte positions and crc helper for the write-frame builder
package mwfb_pkg;

    localparam int DATA_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int POS_W   = 4;
    localparam int ADDR_W  = 4;
    localparam int PDATA_W = 32;

    localparam logic [COUNT_W-1:0] MAX_REGISTERS = 7'd123;
    localparam logic [DATA_W-1:0]  CRC_INIT      = 16'hFFFF;
    localparam logic [DATA_W-1:0]  CRC_POLY      = 16'hA001;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SLAVE_ADDRESS  = 2'd0;
    localparam logic [1:0] REG_FUNCTION_CODE  = 2'd1;
    localparam logic [1:0] REG_START_REGISTER = 2'd2;
    localparam logic [1:0] REG_REGISTER_COUNT = 2'd3;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_ADDR     = 4'd0;
    localparam logic [POS_W-1:0] POS_FUNC     = 4'd1;
    localparam logic [POS_W-1:0] POS_START_HI = 4'd2;
    localparam logic [POS_W-1:0] POS_START_LO = 4'd3;
    localparam logic [POS_W-1:0] POS_COUNT_HI = 4'd4;
    localparam logic [POS_W-1:0] POS_COUNT_LO = 4'd5;
    localparam logic [POS_W-1:0] POS_BYTES    = 4'd6;
    localparam logic [POS_W-1:0] POS_VALUE_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_VALUE_LO = 4'd8;
    localparam logic [POS_W-1:0] POS_CRC_LO   = 4'd9;
    localparam logic [POS_W-1:0] POS_CRC_HI   = 4'd10;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [DATA_W-1:0] crc_t;

    function automatic crc_t crc_byte(input crc_t crc_in, input byte_t b);
        crc_t c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/modbus_write_frame_builder.sv
// modbus rtu write-multiple-registers frame builder with crc-16
//
// Each accepted item is one 16-bit register value; while m_ready is high the
// block sends out the frame one byte per cycle on the m_ channel. The first
// value of a frame is preceded by seven header bytes (slave address,
// function code, start register high/low, count high/low, byte count), every
// value adds its high and low byte, and the last value of a frame is followed
// by the crc low and high byte. The bytes leave through a single byte-wide
// output register; the crc is updated over each header and value byte as it
// leaves. Only one value is held, so a new item is taken in the cycle in
// which the last byte of the current one moves into the output register.
// Registers (byte addresses): 0x0 slave address, 0x4 function code,
// 0x8 start register, 0xC register count (0 is used as 1, above 123 as 123);
// write them only while no frame is in progress.
module modbus_write_frame_builder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwfb_pkg::ADDR_W-1:0]   paddr,
    input  logic [mwfb_pkg::PDATA_W-1:0]  pwdata,
    output logic [mwfb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mwfb_pkg::DATA_W-1:0]   s_register_value,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mwfb_pkg::BYTE_W-1:0]   m_frame_byte,
    output logic                          m_end_of_run,
    output logic                          m_end_of_frame
);
    import mwfb_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0]  slave_address_reg;
    logic [BYTE_W-1:0]  function_code_reg;
    logic [DATA_W-1:0]  start_register_reg;
    logic [COUNT_W-1:0] register_count_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg  <= 8'd1;
            function_code_reg  <= 8'd16;
            start_register_reg <= '0;
            register_count_reg <= 7'd1;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_SLAVE_ADDRESS:  slave_address_reg  <= pwdata[BYTE_W-1:0];
                REG_FUNCTION_CODE:  function_code_reg  <= pwdata[BYTE_W-1:0];
                REG_START_REGISTER: start_register_reg <= pwdata[DATA_W-1:0];
                REG_REGISTER_COUNT: register_count_reg <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SLAVE_ADDRESS:  prdata = {24'd0, slave_address_reg};
            REG_FUNCTION_CODE:  prdata = {24'd0, function_code_reg};
            REG_START_REGISTER: prdata = {16'd0, start_register_reg};
            REG_REGISTER_COUNT: prdata = {25'd0, register_count_reg};
            default:            prdata = '0;
        endcase
    end

    // effective count
    logic [COUNT_W-1:0] count_used;
    always_comb begin
        if (register_count_reg == '0) begin
            count_used = 7'd1;
        end else if (register_count_reg > MAX_REGISTERS) begin
            count_used = MAX_REGISTERS;
        end else begin
            count_used = register_count_reg;
        end
    end

    // current item and frame state
    logic               item_valid_reg;
    logic [DATA_W-1:0]  item_value_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [COUNT_W-1:0] value_index_reg;
    logic [COUNT_W-1:0] value_index_next;
    crc_t               crc_reg;
    crc_t               crc_next;

    // output register
    logic               m_valid_reg;
    logic [BYTE_W-1:0]  m_frame_byte_reg;
    logic               m_end_of_run_reg;
    logic               m_end_of_frame_reg;

    logic               advance;
    logic               last_value;
    logic               item_done;
    logic [BYTE_W-1:0]  byte_sel;
    logic               byte_eor;
    logic               byte_eof;

    assign advance    = item_valid_reg && (!m_valid_reg || m_ready);
    assign last_value = ({1'b0, value_index_reg} + 8'd1) >= {1'b0, count_used};

    always_comb begin
        byte_eor = 1'b0;
        byte_eof = 1'b0;
        unique case (pos_reg)
            POS_ADDR:     byte_sel = slave_address_reg;
            POS_FUNC:     byte_sel = function_code_reg;
            POS_START_HI: byte_sel = start_register_reg[15:8];
            POS_START_LO: byte_sel = start_register_reg[7:0];
            POS_COUNT_HI: byte_sel = '0;
            POS_COUNT_LO: byte_sel = {1'b0, count_used};
            POS_BYTES:    byte_sel = {count_used, 1'b0};
            POS_VALUE_HI: byte_sel = item_value_reg[15:8];
            POS_VALUE_LO: begin
                byte_sel = item_value_reg[7:0];
                byte_eor = !last_value;
            end
            POS_CRC_LO:   byte_sel = crc_reg[7:0];
            POS_CRC_HI: begin
                byte_sel = crc_reg[15:8];
                byte_eor = 1'b1;
                byte_eof = 1'b1;
            end
            default:      byte_sel = '0;
        endcase
    end

    assign item_done = advance && byte_eor;
    assign s_ready   = !item_valid_reg || item_done;

    always_comb begin
        pos_next         = pos_reg;
        value_index_next = value_index_reg;
        crc_next         = crc_reg;
        if (advance) begin
            if (byte_eof) begin
                pos_next         = POS_ADDR;
                value_index_next = '0;
                crc_next         = CRC_INIT;
            end else if (pos_reg == POS_VALUE_LO) begin
                crc_next = crc_byte(crc_reg, byte_sel);
                if (last_value) begin
                    pos_next = POS_CRC_LO;
                end else begin
                    pos_next         = POS_VALUE_HI;
                    value_index_next = value_index_reg + 7'd1;
                end
            end else if (pos_reg == POS_CRC_LO) begin
                pos_next = POS_CRC_HI;
            end else begin
                crc_next = crc_byte(crc_reg, byte_sel);
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg  <= 1'b0;
            pos_reg         <= POS_ADDR;
            value_index_reg <= '0;
            crc_reg         <= CRC_INIT;
            m_valid_reg     <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            value_index_reg <= value_index_next;
            crc_reg         <= crc_next;
            if (s_valid && s_ready) begin
                item_valid_reg <= 1'b1;
            end else if (item_done) begin
                item_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_value_reg <= s_register_value;
        end
        if (advance) begin
            m_frame_byte_reg   <= byte_sel;
            m_end_of_run_reg   <= byte_eor;
            m_end_of_frame_reg <= byte_eof;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_byte   = m_frame_byte_reg;
    assign m_end_of_run   = m_end_of_run_reg;
    assign m_end_of_frame = m_end_of_frame_reg;

endmodule

FILE: bench/modbus_write_frame_builder_test.sv
// testbench for the modbus write-frame builder: predicted byte stream checked against dut
`timescale 1ns / 1ps

module modbus_write_frame_builder_test;
    import mwfb_pkg::*;

    localparam int LONG_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int MAX_SHOWN        = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              end_of_run;
        logic              end_of_frame;
    } frame_byte_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic [DATA_W-1:0]    s_register_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_W-1:0]    m_frame_byte;
    logic                 m_end_of_run;
    logic                 m_end_of_frame;

    // configuration as the block should hold it
    logic [BYTE_W-1:0]    cfg_slave    = 8'd1;
    logic [BYTE_W-1:0]    cfg_function = 8'd16;
    logic [DATA_W-1:0]    cfg_start    = 16'd0;
    logic [COUNT_W-1:0]   cfg_count    = 7'd1;

    // frame progress and crc as the block should hold them
    logic [COUNT_W-1:0]   frame_pos = '0;
    logic [DATA_W-1:0]    frame_crc = CRC_INIT;

    frame_byte_t          expected_bytes[$];

    int  send_idle_pct = 33;
    int  recv_idle_pct = 74;
    bit  hold_output   = 1'b0;
    int  error_count   = 0;
    int  values_accepted = 0;
    int  bytes_checked = 0;
    int  frames_checked = 0;
    int  quiet_cycles  = 0;

    modbus_write_frame_builder u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_register_value (s_register_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_byte     (m_frame_byte),
        .m_end_of_run     (m_end_of_run),
        .m_end_of_frame   (m_end_of_frame)
    );

    always #2 aclk = ~aclk;

    function automatic logic [DATA_W-1:0] crc16_update(input logic [DATA_W-1:0] acc,
                                                       input logic [BYTE_W-1:0] b);
        logic [DATA_W-1:0] r;
        logic              fb;
        r = acc;
        for (int i = 0; i < BYTE_W; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] effective_count(input logic [COUNT_W-1:0] c);
        if (c == '0) begin
            return 7'd1;
        end
        if (c > MAX_REGISTERS) begin
            return MAX_REGISTERS;
        end
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        if ($urandom_range(7) == 0) begin
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        return DATA_W'($urandom);
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit feed_crc,
                             input bit last_of_item, input bit last_of_frame);
        expected_bytes.push_back('{data: b, end_of_run: last_of_item,
                                   end_of_frame: last_of_frame});
        if (feed_crc) begin
            frame_crc = crc16_update(frame_crc, b);
        end
    endtask

    task automatic predict_value_bytes(input logic [DATA_W-1:0] v);
        logic [COUNT_W-1:0] cnt;
        bit                 closes;
        cnt    = effective_count(cfg_count);
        closes = (int'(frame_pos) + 1 >= int'(cnt));
        if (frame_pos == '0) begin
            frame_crc = CRC_INIT;
            push_byte(cfg_slave, 1, 0, 0);
            push_byte(cfg_function, 1, 0, 0);
            push_byte(cfg_start[15:8], 1, 0, 0);
            push_byte(cfg_start[7:0], 1, 0, 0);
            push_byte(BYTE_W'(cnt >> BYTE_W), 1, 0, 0);
            push_byte(BYTE_W'(cnt), 1, 0, 0);
            push_byte({cnt, 1'b0}, 1, 0, 0);
        end
        push_byte(v[15:8], 1, 0, 0);
        push_byte(v[7:0], 1, !closes, 0);
        if (closes) begin
            push_byte(frame_crc[7:0], 0, 0, 0);
            push_byte(frame_crc[15:8], 0, 1, 1);
            frame_pos = '0;
            frame_crc = CRC_INIT;
        end else begin
            frame_pos = frame_pos + 1'b1;
        end
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        error_count++;
        if (error_count <= MAX_SHOWN) begin
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        end
    endtask

    // predictor and checker share one edge so acceptance order is fixed
    always @(posedge aclk) begin
        frame_byte_t want;
        if (aresetn === 1'b1 && s_valid === 1'b1 && s_ready === 1'b1) begin
            predict_value_bytes(s_register_value);
            values_accepted++;
        end
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                note_mismatch("frame byte with nothing expected", 16'h0, 16'(m_frame_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (m_frame_byte !== want.data) begin
                    note_mismatch("frame_byte", 16'(want.data), 16'(m_frame_byte));
                end
                if (m_end_of_run !== want.end_of_run) begin
                    note_mismatch("end_of_run", 16'(want.end_of_run), 16'(m_end_of_run));
                end
                if (m_end_of_frame !== want.end_of_frame) begin
                    note_mismatch("end_of_frame", 16'(want.end_of_frame), 16'(m_end_of_frame));
                end
                bytes_checked++;
                if (want.end_of_frame) begin
                    frames_checked++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready)
            || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("[modbus_write_frame_builder] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side, long hold counted here
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_output) begin
                hold_output = 1'b0;
                repeat (LONG_HOLD_CYCLES) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_value(input logic [DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_register_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_output_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
    endtask

    // finish the open frame so registers change only between frames
    task automatic close_frame();
        int remaining;
        wait_output_drained();
        remaining = (frame_pos == '0) ? 0 : int'(effective_count(cfg_count)) - int'(frame_pos);
        repeat (remaining) send_value(random_value());
        if (remaining != 0) begin
            wait_output_drained();
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SLAVE_ADDRESS:  cfg_slave    = value[7:0];
            REG_FUNCTION_CODE:  cfg_function = value[7:0];
            REG_START_REGISTER: cfg_start    = value[15:0];
            REG_REGISTER_COUNT: cfg_count    = value[6:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic test_default_frame();
        send_value(16'h0000);
        send_value(16'hFFFF);
        send_value(16'hA55A);
    endtask

    task automatic test_header_extremes();
        close_frame();
        write_register(REG_SLAVE_ADDRESS, 32'hFFFF_FFFF);
        write_register(REG_FUNCTION_CODE, 32'h0000_0000);
        write_register(REG_START_REGISTER, 32'h0000_FFFF);
        write_register(REG_REGISTER_COUNT, 32'hFFFF_FF83);
        send_value(16'hFFFF);
        send_value(16'h0000);
        send_value(16'h8001);
        close_frame();
        write_register(REG_SLAVE_ADDRESS, 32'h0000_0000);
        write_register(REG_FUNCTION_CODE, 32'h0000_00FF);
        write_register(REG_START_REGISTER, 32'hABCD_0000);
        write_register(REG_REGISTER_COUNT, 32'h0000_0002);
        send_value(16'h7FFE);
        send_value(16'h5AA5);
    endtask

    // count of zero acts as one
    task automatic test_count_zero();
        close_frame();
        write_register(REG_REGISTER_COUNT, 32'h0000_0080);
        send_value(16'h1234);
        send_value(16'hEDCB);
    endtask

    task automatic test_random_traffic(input int n_values);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_values) begin
            close_frame();
            if ($urandom_range(3) != 0) begin
                write_register(REG_SLAVE_ADDRESS, $urandom);
            end
            if ($urandom_range(3) != 0) begin
                write_register(REG_FUNCTION_CODE, $urandom);
            end
            if ($urandom_range(3) != 0) begin
                write_register(REG_START_REGISTER, $urandom);
            end
            write_register(REG_REGISTER_COUNT,
                           ($urandom & 32'hFFFF_FF80) | PDATA_W'($urandom_range(0, 9)));
            burst = $urandom_range(4, 16);
            repeat (burst) send_value(random_value());
            sent += burst;
        end
    endtask

    task automatic test_output_backpressure(input int n_values);
        hold_output = 1'b1;
        repeat (n_values) send_value(random_value());
    endtask

    task automatic test_sender_pause();
        repeat (5) send_value(random_value());
        wait_output_drained();
        repeat (5) send_value(random_value());
    endtask

    // count above the limit is cut to the largest frame
    task automatic test_longest_frame();
        close_frame();
        write_register(REG_SLAVE_ADDRESS, $urandom);
        write_register(REG_START_REGISTER, $urandom);
        write_register(REG_REGISTER_COUNT, 32'h0000_007F);
        repeat (int'(MAX_REGISTERS)) send_value(random_value());
        close_frame();
    endtask

    initial begin
        aresetn          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        s_valid          <= 1'b0;
        s_register_value <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 74;
        test_default_frame();
        test_header_extremes();
        test_count_zero();
        test_random_traffic(50);
        test_output_backpressure(24);

        send_idle_pct = 74;
        recv_idle_pct = 33;
        test_sender_pause();
        test_longest_frame();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(50);
        test_output_backpressure(24);

        wait_output_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_bytes.size() != 0) begin
            note_mismatch("expected bytes left over", 16'(expected_bytes.size()), 16'h0);
        end
        $display("ran %0d register values into %0d frames, %0d bytes compared",
                 values_accepted, frames_checked, bytes_checked);
        $display("header extremes, count clamping low and high, long output hold, "
                 , "sender pause and three idle mixes");
        if (error_count == 0) begin
            $display("[modbus_write_frame_builder] OK");
        end else begin
            $display("[modbus_write_frame_builder] ERROR");
        end
        $finish;
    end

endmodule
